>>> hw/rtl/sphere_segment_contact_core_macros.svh
// assertion macros for the sphere segment contact core checker
// no dependencies; included by the checker file
`ifndef SPHERE_SEGMENT_CONTACT_CORE_MACROS_SVH
`define SPHERE_SEGMENT_CONTACT_CORE_MACROS_SVH

// same-cycle implication, disabled while rst_cond is high
`define SSC_ASSERT_IMP(label, clk, rst_cond, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst_cond) (ante) |-> (cons)) \
    else $error("ssc check failed");

// next-cycle implication, disabled while rst_cond is high
`define SSC_ASSERT_NEXT(label, clk, rst_cond, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst_cond) (ante) |=> (cons)) \
    else $error("ssc check failed");

`endif

>>> hw/rtl/ssc_pkg.sv
// shared widths, stage payload types and saturation helper
// for the sphere segment contact core; no dependencies
`default_nettype none

package ssc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int CW          = COORD_WIDTH;
  localparam int DIR_W       = 18;
  localparam int RAD_W       = 31;
  localparam int LEN_W       = 31;
  localparam int FRAC_W      = 16;
  localparam int EXT_W       = 72;
  // clamped center-origin difference
  localparam int PW          = (CW + 1 > 46) ? 46 : CW + 1;
  localparam int PRD_W       = PW + DIR_W;
  localparam int T_W         = LEN_W;
  localparam int TP_W        = DIR_W + T_W + 1;
  localparam int RND_W       = TP_W - FRAC_W;
  localparam int SW          = ((CW > RND_W) ? CW : RND_W) + 1;
  localparam int DW          = SW + 1;
  localparam int MSB_W       = $clog2(DW);
  localparam int NA_W        = 31;
  localparam int SQ_W        = 2 * NA_W;
  localparam int N2_W        = SQ_W + 2;
  localparam int ROOT_W      = N2_W / 2;
  localparam int DIV_W       = RAD_W;
  localparam int NUM_W       = NA_W + RAD_W + 1;
  localparam int HALF_LSB    = 1 << (FRAC_W - 1);

  localparam int IN_BITS     = 6 * CW + RAD_W + 3 * DIR_W + LEN_W;
  localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 6 * CW + 3;
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

  localparam logic signed [EXT_W-1:0] DIFF_LIM = EXT_W'(1) << 44;
  localparam logic signed [EXT_W-1:0] CMAX     = (EXT_W'(1) << (CW - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] CMIN     = -CMAX - EXT_W'(1);

  typedef logic [2:0][CW-1:0] vec3_t;

  // front pipeline payload, each stage fills its own fields
  typedef struct packed {
    vec3_t                  c;
    vec3_t                  o;
    logic [2:0][DIR_W-1:0]  dir;
    logic [RAD_W-1:0]       r;
    logic [LEN_W-1:0]       len;
    logic [2:0][PW-1:0]     dif;
    logic [2:0][PRD_W-1:0]  prod;
    logic [T_W-1:0]         t;
    logic [2:0][TP_W-1:0]   tp;
    vec3_t                  seg;
    logic [2:0]             neg;
    logic [2:0][DW-1:0]     a;
    logic [DW-1:0]          m;
    logic [MSB_W-1:0]       msb;
    logic                   small_d;
    logic                   zero_d;
    logic [2:0][NA_W-1:0]   na;
    logic [2:0][SQ_W-1:0]   sq;
    logic [SQ_W-1:0]        rr;
    logic                   hit;
    logic [N2_W-1:0]        n2;
  } fs_t;

  // sideband carried alongside the root and divide pipelines
  typedef struct packed {
    vec3_t                  c;
    vec3_t                  seg;
    logic [2:0]             neg;
    logic [2:0][NA_W-1:0]   na;
    logic [RAD_W-1:0]       r;
    logic                   hit;
    logic                   degen;
  } sb_t;

  // divide pipeline payload
  typedef struct packed {
    sb_t                    sb;
    logic [ROOT_W-1:0]      n;
    logic [2:0][NUM_W-1:0]  rem;
    logic [2:0][DIV_W-1:0]  q;
  } dv_t;

  typedef struct packed {
    logic  hit;
    logic  separated;
    logic  degenerate;
    vec3_t seg;
    vec3_t surf;
  } res_t;

  function automatic logic [CW-1:0] sat_cw(input logic signed [EXT_W-1:0] x);
    logic [CW-1:0] y;
    if (x > CMAX) begin
      y = CMAX[CW-1:0];
    end else if (x < CMIN) begin
      y = CMIN[CW-1:0];
    end else begin
      y = x[CW-1:0];
    end
    return y;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ssc_front.sv
// front pipeline: projection, clamp, segment point, normalize, hit test
// depends on ssc_pkg
`default_nettype none

module ssc_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire ssc_pkg::fs_t in_item,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [ssc_pkg::N2_W-1:0] out_n2,
  output ssc_pkg::sb_t      out_sb
);
  import ssc_pkg::*;

  localparam int FS_N = 9;

  fs_t              st_r   [FS_N];
  fs_t              st_nxt [FS_N];
  logic [FS_N-1:0]  v_r;
  logic [FS_N:0]    en;

  assign en[FS_N] = out_ready;
  for (genvar k = 0; k < FS_N; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign in_ready = en[0];

  // difference, clamped to +-2^44
  always_comb begin : s0_comb
    logic signed [CW:0]      df;
    logic signed [EXT_W-1:0] dl;
    st_nxt[0] = in_item;
    for (int i = 0; i < 3; i++) begin
      df = {in_item.c[i][CW-1], in_item.c[i]} - {in_item.o[i][CW-1], in_item.o[i]};
      dl = EXT_W'(df);
      if (dl > DIFF_LIM) dl = DIFF_LIM;
      if (dl < -DIFF_LIM) dl = -DIFF_LIM;
      st_nxt[0].dif[i] = dl[PW-1:0];
    end
  end

  always_comb begin : s1_comb
    logic signed [PRD_W-1:0] pr;
    st_nxt[1] = st_r[0];
    for (int i = 0; i < 3; i++) begin
      pr = $signed(st_r[0].dif[i]) * $signed(st_r[0].dir[i]);
      st_nxt[1].prod[i] = pr;
    end
  end

  // dot product, clamp to [0, len], round to t
  always_comb begin : s2_comb
    logic signed [EXT_W-1:0] dot;
    logic signed [EXT_W-1:0] lim;
    logic signed [EXT_W-1:0] pr;
    st_nxt[2] = st_r[1];
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      dot = dot + EXT_W'($signed(st_r[1].prod[i]));
    end
    lim = EXT_W'({st_r[1].len, {FRAC_W{1'b0}}});
    if (dot < 0) dot = '0;
    if (dot > lim) dot = lim;
    pr = dot + EXT_W'(HALF_LSB);
    st_nxt[2].t = pr[FRAC_W+T_W-1:FRAC_W];
  end

  always_comb begin : s3_comb
    logic signed [TP_W-1:0] tp;
    st_nxt[3] = st_r[2];
    for (int i = 0; i < 3; i++) begin
      tp = $signed(st_r[2].dir[i]) * $signed({1'b0, st_r[2].t});
      st_nxt[3].tp[i] = tp;
    end
  end

  // segment point and offset from center
  always_comb begin : s4_comb
    logic signed [TP_W-1:0]  y;
    logic signed [RND_W-1:0] rnd;
    logic signed [SW-1:0]    s;
    logic signed [DW-1:0]    d;
    st_nxt[4] = st_r[3];
    for (int i = 0; i < 3; i++) begin
      y   = st_r[3].tp[i] + TP_W'(HALF_LSB);
      rnd = RND_W'(y >>> FRAC_W);
      s   = SW'(rnd) + SW'($signed(st_r[3].o[i]));
      d   = DW'(s) - DW'($signed(st_r[3].c[i]));
      st_nxt[4].seg[i] = sat_cw(EXT_W'(s));
      st_nxt[4].neg[i] = d[DW-1];
      st_nxt[4].a[i]   = d[DW-1] ? DW'(-d) : DW'(d);
    end
  end

  // largest magnitude and its leading one
  always_comb begin : s5_comb
    logic [DW-1:0] mx;
    st_nxt[5] = st_r[4];
    mx = st_r[4].a[0];
    if (st_r[4].a[1] > mx) mx = st_r[4].a[1];
    if (st_r[4].a[2] > mx) mx = st_r[4].a[2];
    st_nxt[5].m = mx;
    st_nxt[5].msb = '0;
    for (int j = 0; j < DW; j++) begin
      if (mx[j]) st_nxt[5].msb = MSB_W'(j);
    end
    st_nxt[5].zero_d  = (mx == '0);
    st_nxt[5].small_d = (mx[DW-1:NA_W] == '0);
  end

  // normalize so the largest lands in [2^30, 2^31); squares for hit
  always_comb begin : s6_comb
    logic [DW-1:0] sh;
    st_nxt[6] = st_r[5];
    for (int i = 0; i < 3; i++) begin
      if (st_r[5].msb >= MSB_W'(NA_W - 1)) begin
        sh = st_r[5].a[i] >> (st_r[5].msb - MSB_W'(NA_W - 1));
      end else begin
        sh = st_r[5].a[i] << (MSB_W'(NA_W - 1) - st_r[5].msb);
      end
      st_nxt[6].na[i] = sh[NA_W-1:0];
      st_nxt[6].sq[i] = SQ_W'(st_r[5].a[i][NA_W-1:0]) * SQ_W'(st_r[5].a[i][NA_W-1:0]);
    end
    st_nxt[6].rr = SQ_W'(st_r[5].r) * SQ_W'(st_r[5].r);
  end

  always_comb begin : s7_comb
    logic [N2_W-1:0] sum;
    st_nxt[7] = st_r[6];
    sum = N2_W'(st_r[6].sq[0]) + N2_W'(st_r[6].sq[1]) + N2_W'(st_r[6].sq[2]);
    if (st_r[6].zero_d) begin
      st_nxt[7].hit = (st_r[6].r != '0);
    end else begin
      st_nxt[7].hit = st_r[6].small_d && (sum < N2_W'(st_r[6].rr));
    end
    for (int i = 0; i < 3; i++) begin
      st_nxt[7].sq[i] = SQ_W'(st_r[6].na[i]) * SQ_W'(st_r[6].na[i]);
    end
  end

  always_comb begin : s8_comb
    st_nxt[8] = st_r[7];
    st_nxt[8].n2 = N2_W'(st_r[7].sq[0]) + N2_W'(st_r[7].sq[1]) + N2_W'(st_r[7].sq[2]);
  end

  for (genvar k = 0; k < FS_N; k++) begin : g_stg
    logic v_in;
    if (k == 0) begin : g_first
      assign v_in = in_valid;
    end else begin : g_next
      assign v_in = v_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_valid    = v_r[FS_N-1];
  assign out_n2       = st_r[FS_N-1].n2;
  assign out_sb.c     = st_r[FS_N-1].c;
  assign out_sb.seg   = st_r[FS_N-1].seg;
  assign out_sb.neg   = st_r[FS_N-1].neg;
  assign out_sb.na    = st_r[FS_N-1].na;
  assign out_sb.r     = st_r[FS_N-1].r;
  assign out_sb.hit   = st_r[FS_N-1].hit;
  assign out_sb.degen = st_r[FS_N-1].zero_d;

endmodule

`default_nettype wire

>>> hw/rtl/ssc_sqrt.sv
// pipelined floor square root, one result bit per stage
// depends on ssc_pkg
`default_nettype none

module ssc_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [ssc_pkg::N2_W-1:0]  in_n2,
  input  wire ssc_pkg::sb_t              in_sb,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [ssc_pkg::ROOT_W-1:0]     out_root,
  output ssc_pkg::sb_t                   out_sb
);
  import ssc_pkg::*;

  logic [N2_W-1:0]   rem_r [ROOT_W];
  logic [ROOT_W-1:0] q_r   [ROOT_W];
  sb_t               sb_r  [ROOT_W];
  logic [ROOT_W-1:0] v_r;
  logic [ROOT_W:0]   en;

  assign en[ROOT_W] = out_ready;
  assign in_ready   = en[0];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
    localparam int B = ROOT_W - 1 - k;
    logic [N2_W-1:0]   rem_in;
    logic [ROOT_W-1:0] q_in;
    sb_t               sb_in;
    logic              v_in;
    logic [N2_W+1:0]   trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = in_n2;
      assign q_in   = '0;
      assign sb_in  = in_sb;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign sb_in  = sb_r[k-1];
      assign v_in   = v_r[k-1];
    end

    // (q + 2^B)^2 - q^2, q holds only bits above B
    assign trial = ((N2_W+2)'(q_in) << (B + 1)) | ((N2_W+2)'(1) << (2 * B));
    assign take  = (N2_W+2)'(rem_in) >= trial;
    assign en[k] = !v_r[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= take ? N2_W'((N2_W+2)'(rem_in) - trial) : rem_in;
        q_r[k]   <= take ? (q_in | (ROOT_W'(1) << B)) : q_in;
        sb_r[k]  <= sb_in;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = q_r[ROOT_W-1];
  assign out_sb    = sb_r[ROOT_W-1];

endmodule

`default_nettype wire

>>> hw/rtl/ssc_div.sv
// surface offset: scale by radius, pipelined restoring divide by the root,
// then center plus signed offset with saturation; depends on ssc_pkg
`default_nettype none

module ssc_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [ssc_pkg::ROOT_W-1:0] in_root,
  input  wire ssc_pkg::sb_t              in_sb,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output ssc_pkg::res_t                  out_res
);
  import ssc_pkg::*;

  // multiply, add half root, DIV_W divide steps
  localparam int DV_N = DIV_W + 2;

  dv_t             dv_r   [DV_N];
  dv_t             dv_nxt [DV_N];
  logic [DV_N-1:0] v_r;
  logic [DV_N:0]   en;
  res_t            res_r;
  res_t            res_nxt;
  logic            res_v_r;
  logic            res_en;

  assign res_en   = !res_v_r || out_ready;
  assign en[DV_N] = res_en;
  assign in_ready = en[0];

  always_comb begin : p0_comb
    dv_nxt[0]    = '0;
    dv_nxt[0].sb = in_sb;
    dv_nxt[0].n  = in_root;
    for (int i = 0; i < 3; i++) begin
      dv_nxt[0].rem[i] = NUM_W'(in_sb.na[i]) * NUM_W'(in_sb.r);
    end
  end

  always_comb begin : p1_comb
    dv_nxt[1] = dv_r[0];
    for (int i = 0; i < 3; i++) begin
      dv_nxt[1].rem[i] = dv_r[0].rem[i] + NUM_W'(dv_r[0].n >> 1);
    end
  end

  for (genvar j = 0; j < DIV_W; j++) begin : g_div
    localparam int B = DIV_W - 1 - j;
    always_comb begin
      logic [NUM_W-1:0] dvs;
      dv_nxt[j+2] = dv_r[j+1];
      dvs = NUM_W'(dv_r[j+1].n) << B;
      for (int i = 0; i < 3; i++) begin
        if (dv_r[j+1].rem[i] >= dvs) begin
          dv_nxt[j+2].rem[i] = dv_r[j+1].rem[i] - dvs;
          dv_nxt[j+2].q[i]   = dv_r[j+1].q[i] | (DIV_W'(1) << B);
        end
      end
    end
  end

  for (genvar k = 0; k < DV_N; k++) begin : g_stg
    logic v_in;
    if (k == 0) begin : g_first
      assign v_in = in_valid;
    end else begin : g_next
      assign v_in = v_r[k-1];
    end
    assign en[k] = !v_r[k] || en[k+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  always_comb begin : fin_comb
    logic signed [EXT_W-1:0] off;
    logic signed [EXT_W-1:0] sum;
    res_nxt.hit        = dv_r[DV_N-1].sb.hit;
    res_nxt.separated  = !dv_r[DV_N-1].sb.hit;
    res_nxt.degenerate = dv_r[DV_N-1].sb.degen;
    res_nxt.seg        = dv_r[DV_N-1].sb.seg;
    for (int i = 0; i < 3; i++) begin
      off = EXT_W'(dv_r[DV_N-1].q[i]);
      if (dv_r[DV_N-1].sb.neg[i]) off = -off;
      sum = EXT_W'($signed(dv_r[DV_N-1].sb.c[i])) + off;
      res_nxt.surf[i] = dv_r[DV_N-1].sb.degen ? dv_r[DV_N-1].sb.c[i] : sat_cw(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (res_en) begin
      res_v_r <= v_r[DV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_v_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

>>> hw/rtl/sphere_segment_contact_core.sv
// sphere versus ray segment closest point contact core, top level
// throughput: one transaction per cycle while the output is not stalled, set by the fully pipelined root and divider
// every stage holds on its own valid bit, so bubbles close up under output stall
// reset: synchronous active-low rst_n empties all stage valid bits; no other state
`default_nettype none

module sphere_segment_contact_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // center_x, center_y, center_z, radius, origin_x, origin_y, origin_z,
  // dir_x, dir_y, dir_z, seg_length, zero fill
  input  wire logic [ssc_pkg::IN_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // hit, separated, degenerate, seg_point_x, seg_point_y, seg_point_z,
  // surf_point_x, surf_point_y, surf_point_z, zero fill
  output logic [ssc_pkg::OUT_W-1:0]       out_tdata
);
  import ssc_pkg::*;

  // input field offsets in tdata
  localparam int OFF_R   = 3 * CW;
  localparam int OFF_O   = OFF_R + RAD_W;
  localparam int OFF_D   = OFF_O + 3 * CW;
  localparam int OFF_LEN = OFF_D + 3 * DIR_W;
  // output field offsets
  localparam int OFF_SEG  = 3;
  localparam int OFF_SURF = OFF_SEG + 3 * CW;

  fs_t              item;
  logic             fr_valid;
  logic             fr_ready;
  logic [N2_W-1:0]  fr_n2;
  sb_t              fr_sb;
  logic             sq_valid;
  logic             sq_ready;
  logic [ROOT_W-1:0] sq_root;
  sb_t              sq_sb;
  res_t             res;

  // unpack the input transaction; later fields are filled by the stages
  always_comb begin
    item = '0;
    for (int i = 0; i < 3; i++) begin
      item.c[i]   = in_tdata[i*CW +: CW];
      item.o[i]   = in_tdata[OFF_O + i*CW +: CW];
      item.dir[i] = in_tdata[OFF_D + i*DIR_W +: DIR_W];
    end
    item.r   = in_tdata[OFF_R +: RAD_W];
    item.len = in_tdata[OFF_LEN +: LEN_W];
  end

  // projection, segment point, hit test and normalized squared distance
  ssc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_n2    (fr_n2),
    .out_sb    (fr_sb)
  );

  // distance magnitude of the normalized offset
  ssc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_n2     (fr_n2),
    .in_sb     (fr_sb),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root),
    .out_sb    (sq_sb)
  );

  // radius scaling and surface point; last register is the output register
  ssc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_root   (sq_root),
    .in_sb     (sq_sb),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  always_comb begin
    out_tdata    = '0;
    out_tdata[0] = res.hit;
    out_tdata[1] = res.separated;
    out_tdata[2] = res.degenerate;
    for (int i = 0; i < 3; i++) begin
      out_tdata[OFF_SEG + i*CW +: CW]  = res.seg[i];
      out_tdata[OFF_SURF + i*CW +: CW] = res.surf[i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ssc_checker.sv
// port-level checks for the contact core, attached by bind
// depends on ssc_pkg and the assertion macro header
`default_nettype none
`include "sphere_segment_contact_core_macros.svh"

module ssc_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_tvalid,
  input wire logic                     in_tready,
  input wire logic [ssc_pkg::IN_W-1:0] in_tdata,
  input wire logic                     out_tvalid,
  input wire logic                     out_tready,
  input wire logic [ssc_pkg::OUT_W-1:0] out_tdata
);
  import ssc_pkg::*;

  logic in_seen;
  assign in_seen = in_tvalid && in_tready && (in_tdata != '0 || in_tdata == '0);

  // stalled result transaction holds
  `SSC_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // hit and separated are complements
  `SSC_ASSERT_IMP(a_hit_sep, clk, !rst_n, out_tvalid, out_tdata[0] != out_tdata[1])
  // zero distance puts the surface point on the segment point
  `SSC_ASSERT_IMP(a_degen_pt, clk, !rst_n, out_tvalid && out_tdata[2], out_tdata[3 +: 3*CW] == out_tdata[3 + 3*CW +: 3*CW])
  // pipeline is empty right after reset
  `SSC_ASSERT_NEXT(a_rst_empty, clk, 1'b0, !rst_n, !out_tvalid)
  // nothing accepted during reset leaks out
  `SSC_ASSERT_NEXT(a_rst_noacc, clk, 1'b0, !rst_n && in_seen, !out_tvalid)

endmodule

bind sphere_segment_contact_core ssc_checker u_ssc_checker (.*);

`default_nettype wire

>>> tb/sv/tb_sphere_segment_contact_core.sv
// testbench for the sphere segment contact core: directed and random contact queries
// checked against a behavioral closest-point predictor; depends on ssc_pkg and the core
`timescale 1ns / 1ps

module tb_sphere_segment_contact_core;
  import ssc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 120;
  localparam int STALL_LEN   = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  logic [IN_W-1:0]   query_q[$];
  logic [OUT_W-1:0]  contact_q[$];
  int                n_accepted = 0;
  int                n_mismatch = 0;
  int                cycle_cnt = 0;
  int                send_gap = 0;
  int                recv_gap = 0;
  int                stall_cnt = 0;
  bit                stall_done = 1'b0;
  bit                in_taken = 1'b0;

  sphere_segment_contact_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint clamp_coord(input longint x);
    longint hi;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  // floor((x + half) / 2^16)
  function automatic longint round_half_up(input longint x);
    longint y;
    y = x + 32768;
    if (y >= 0) return y >>> 16;
    return -longint'((longint'(-y) + 65535) >>> 16);
  endfunction

  function automatic logic [OUT_W-1:0] contact_expect(input logic [IN_W-1:0] v);
    longint c[3], o[3], dv[3], s[3], d[3], sf[3];
    longint p, t, lim, diff, off;
    longint unsigned a[3], m, n2, n, r, len, rest, bitv, root;
    bit hit, deg;
    logic [OUT_W-1:0] q;
    p = 0;
    m = 0;
    hit = 1'b0;
    deg = 1'b0;
    r = v[126:96];
    len = v[307:277];
    for (int i = 0; i < 3; i++) begin
      c[i] = $signed(v[32*i +: 32]);
      o[i] = $signed(v[127+32*i +: 32]);
      dv[i] = $signed(v[223+18*i +: 18]);
      diff = c[i] - o[i];
      if (diff > (64'sd1 <<< 44)) diff = 64'sd1 <<< 44;
      if (diff < -(64'sd1 <<< 44)) diff = -(64'sd1 <<< 44);
      p += diff * dv[i];
    end
    lim = longint'(len << 16);
    if (p < 0) p = 0;
    if (p > lim) p = lim;
    t = (p + 32768) >>> 16;
    for (int i = 0; i < 3; i++) begin
      s[i] = o[i] + round_half_up(dv[i] * t);
      d[i] = s[i] - c[i];
      a[i] = (d[i] < 0) ? longint'(-d[i]) : d[i];
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      deg = 1'b1;
      hit = (r > 0);
      for (int i = 0; i < 3; i++) sf[i] = c[i];
    end else begin
      if (m < (64'd1 << 31)) hit = (a[0] * a[0] + a[1] * a[1] + a[2] * a[2]) < r * r;
      // normalize so the largest magnitude sits in [2^30, 2^31)
      while (m >= (64'd1 << 31)) begin
        m >>= 1;
        for (int i = 0; i < 3; i++) a[i] >>= 1;
      end
      while (m < (64'd1 << 30)) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) a[i] <<= 1;
      end
      n2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      rest = n2;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rest) bitv >>= 2;
      while (bitv != 0) begin
        if (rest >= root + bitv) begin
          rest -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      n = root;
      for (int i = 0; i < 3; i++) begin
        off = longint'((a[i] * r + (n >> 1)) / n);
        sf[i] = c[i] + ((d[i] < 0) ? -off : off);
      end
    end
    q = '0;
    q[0] = hit;
    q[1] = ~hit;
    q[2] = deg;
    for (int i = 0; i < 3; i++) begin
      q[3+32*i +: 32] = clamp_coord(s[i]);
      q[99+32*i +: 32] = clamp_coord(sf[i]);
    end
    return q;
  endfunction

  task automatic add_query(input int cx, input int cy, input int cz, input int unsigned rad,
                           input int ox, input int oy, input int oz,
                           input int dx, input int dy, input int dz, input int unsigned len);
    logic [IN_W-1:0] v;
    v = '0;
    v[31:0] = cx;
    v[63:32] = cy;
    v[95:64] = cz;
    v[126:96] = rad[30:0];
    v[158:127] = ox;
    v[190:159] = oy;
    v[222:191] = oz;
    v[240:223] = dx[17:0];
    v[258:241] = dy[17:0];
    v[276:259] = dz[17:0];
    v[307:277] = len[30:0];
    query_q.push_back(v);
  endtask

  function automatic int rand_dir();
    return int'($urandom_range(0, 131072)) - 65536;
  endfunction

  // sender: new data only at the falling edge after a transaction or while idle
  always @(negedge clk) begin
    if (rst_n && (in_taken || !in_tvalid)) begin
      if (send_gap > 0 || query_q.size() == 0) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else begin
        in_tdata <= query_q.pop_front();
        in_tvalid <= 1'b1;
        case ($urandom_range(0, 19))
          0:       send_gap <= $urandom_range(10, 40);
          1, 2, 3, 4, 5: send_gap <= $urandom_range(1, 3);
          default: send_gap <= 0;
        endcase
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off that fills the pipeline
  always @(negedge clk) begin
    if (rst_n) begin
      if (!stall_done && n_accepted >= 300) begin
        out_tready <= 1'b0;
        if (stall_cnt == STALL_LEN) stall_done <= 1'b1;
        stall_cnt <= stall_cnt + 1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        case ($urandom_range(0, 19))
          0:       recv_gap <= $urandom_range(10, 50);
          1, 2, 3: recv_gap <= $urandom_range(1, 3);
          default: recv_gap <= 0;
        endcase
      end
    end
  end

  // monitor: predict each accepted query, check each accepted result
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    bit bad;
    cycle_cnt <= cycle_cnt + 1;
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      contact_q.push_back(contact_expect(in_tdata));
      n_accepted <= n_accepted + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (contact_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result transaction %h", out_tdata);
      end else begin
        want = contact_q.pop_front();
        bad = (want[2:0] !== out_tdata[2:0]);
        for (int i = 0; i < 6; i++) bad |= (want[3+32*i +: 32] !== out_tdata[3+32*i +: 32]);
        bad |= (out_tdata[OUT_W-1:OUT_BITS] !== '0);
        if (bad) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: flags exp %b got %b seg/surf exp %h got %h",
                     want[2:0], out_tdata[2:0], want[194:3], out_tdata[194:3]);
        end
      end
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int bx, by, bz, mode, ax;
    int dd[3];
    // directed: extremes, degenerate, clamps, far apart, non-unit direction
    add_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_query(0, 0, 0, 32'h7fffffff, 0, 0, 0, 65536, 0, 0, 32'h7fffffff);
    add_query(65536, 0, 0, 0, 65536, 0, 0, 65536, 0, 0, 65536);
    add_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h80000000, 32'h80000000, 65536, 65536, 65536, 32'h7fffffff);
    add_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -65536, -65536, -65536, 32'h7fffffff);
    add_query(32'h80000000, 32'h7fffffff, 0, 1, 32'h7fffffff, 32'h80000000, 0,
              -65536, 65536, 0, 32'h7fffffff);
    add_query(10 << 16, 0, 0, 2 << 16, 0, 0, 0, 65536, 0, 0, 20 << 16);
    add_query(30 << 16, 1 << 16, 0, 2 << 16, 0, 0, 0, 65536, 0, 0, 20 << 16);
    add_query(-5 << 16, 0, 0, 6 << 16, 0, 0, 0, 65536, 0, 0, 20 << 16);
    add_query(5 << 16, 3 << 16, 4 << 16, 5 << 16, 0, 0, 0, 65536, 0, 0, 20 << 16);
    add_query(5 << 16, 3 << 16, 4 << 16, (5 << 16) + 1, 0, 0, 0, 65536, 0, 0, 20 << 16);
    add_query(7 << 16, 7 << 16, 7 << 16, 3 << 16, 0, 0, 0, 46341, 46341, 0, 30 << 16);
    add_query(1000, -2000, 3000, 500, 0, 0, 0, -65536, -65536, -65536, 32'h7fffffff);
    add_query(0, 0, 0, 100, 1, 1, 1, 0, 0, 0, 1000);
    add_query(-3 << 16, 2 << 16, 9 << 16, 1 << 16, 4 << 16, -4 << 16, 0,
              0, 0, 65536, 32'h7fffffff);
    add_query(32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0, 0, 65536, 0, 0, 32'h7fffffff);
    for (int k = 0; k < 750; k++) begin
      mode = $urandom_range(0, 9);
      bx = $urandom;
      by = $urandom;
      bz = $urandom;
      ax = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) dd[i] = (i == ax) ? (($urandom & 1) ? 65536 : -65536) : 0;
      if (mode < 5) begin
        // local scene near a random base, axis directions about half the time
        if ($urandom_range(0, 1)) for (int i = 0; i < 3; i++) dd[i] = rand_dir();
        bx = bx >>> 2; by = by >>> 2; bz = bz >>> 2;
        add_query(bx + int'($urandom_range(0, 1 << 21)) - (1 << 20),
                  by + int'($urandom_range(0, 1 << 21)) - (1 << 20),
                  bz + int'($urandom_range(0, 1 << 21)) - (1 << 20),
                  $urandom_range(0, 1 << 21), bx, by, bz, dd[0], dd[1], dd[2],
                  $urandom_range(0, 1 << 22));
      end else if (mode < 8) begin
        add_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  rand_dir(), rand_dir(), rand_dir(), $urandom);
      end else if (mode < 9) begin
        // sphere center on the ray origin
        add_query(bx, by, bz, $urandom_range(0, 3) == 0 ? 0 : $urandom, bx, by, bz,
                  rand_dir(), rand_dir(), rand_dir(), $urandom);
      end else begin
        add_query(bx >>> 8, by >>> 8, bz >>> 8, $urandom >> 8, $urandom >>> 8,
                  $urandom >>> 8, $urandom >>> 8, dd[0], dd[1], dd[2], $urandom >> 6);
      end
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    wait (query_q.size() == 0 && !in_tvalid && contact_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_mismatch == 0 && contact_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
